FILE: sv/fat12cw_pkg.sv
`timescale 1ns / 1ps

package fat12cw_pkg;

    // Field widths of the stream items
    localparam int unsigned TBL_ADDR_W = 13;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CLUSTER_W  = 12;
    localparam int unsigned SECTOR_W   = 20;
    localparam int unsigned START_W    = 16;
    localparam int unsigned SPC_W      = 8;

    // Cluster value limits
    localparam logic [CLUSTER_W-1:0] FIRST_DATA = 12'h002;
    localparam logic [CLUSTER_W-1:0] END_MARK   = 12'hFF8;
    localparam logic [SECTOR_W-1:0]  SECTOR_MAX = 20'hFFFFF;

    // Item operations carried in s_tuser
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_START   = 2'd1,
        OP_ADVANCE = 2'd2
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_DATA_START = 2'd0;
    localparam logic [1:0] CFG_SPC        = 2'd1;

    // Single-port table access
    typedef struct packed {
        logic                  we;
        logic [TBL_ADDR_W-1:0] addr;
        logic [BYTE_W-1:0]     wdata;
    } tbl_req_t;

    // One result item
    typedef struct packed {
        logic                 bad_cluster;
        logic                 chain_end;
        logic [CLUSTER_W-1:0] current_cluster;
        logic [SECTOR_W-1:0]  sector_address;
    } result_t;

endpackage

FILE: sv/fat12_cluster_chain_walker_unit.sv
`timescale 1ns / 1ps
// Steps: an advance from a data cluster goes through ST_RD_LO, ST_RD_HI, ST_MUL and ST_SUM,
// every other item through ST_MUL and ST_SUM; a result still waiting in the output register
// holds ST_SUM. A new item is taken only in ST_IDLE, once the previous result is registered;
// the advance is bound by two sequential reads of the single-port table memory.
// Reset: aresetn (synchronous, active low) clears the current cluster to 0, sets data start
// to 0 and sectors per cluster to 1; the table contents stay undefined until written.

module fat12_cluster_chain_walker_unit #(
    parameter int unsigned TABLE_BYTES = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // table_address[12:0], table_byte[20:13],
                                   // start_cluster[32:21], zero [39:33]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    // Result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // sector_address[19:0], current_cluster[31:20]
    output logic        m_tlast,   // chain_end
    output logic        m_tuser,   // bad_cluster[0]
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [fat12cw_pkg::TBL_ADDR_W:0] TABLE_LIMIT =
        (fat12cw_pkg::TBL_ADDR_W + 1)'(TABLE_BYTES);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RD_LO = 5'b00010,
        ST_RD_HI = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_SUM   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [fat12cw_pkg::CLUSTER_W-1:0]  cluster_reg, cluster_next;
    logic [fat12cw_pkg::START_W-1:0]    data_start_reg, data_start_next;
    logic [fat12cw_pkg::SPC_W-1:0]      spc_reg, spc_next;
    logic [fat12cw_pkg::BYTE_W-1:0]     lo_reg, lo_next;
    logic                               lo_ok_reg, lo_ok_next;
    logic                               hi_ok_reg, hi_ok_next;
    logic                               m_valid_reg, m_valid_next;
    fat12cw_pkg::result_t               out_reg, out_next;

    fat12cw_pkg::tbl_req_t              tbl_req;
    logic [fat12cw_pkg::BYTE_W-1:0]     tbl_rdata;
    fat12cw_pkg::result_t               calc_result;
    logic                               calc_load;

    fat12cw_pkg::op_t                   in_op;
    logic [fat12cw_pkg::TBL_ADDR_W-1:0] in_addr;
    logic [fat12cw_pkg::BYTE_W-1:0]     in_byte;
    logic [fat12cw_pkg::CLUSTER_W-1:0]  in_start;
    logic                               s_xfer;
    logic [fat12cw_pkg::TBL_ADDR_W-1:0] off_lo;
    logic [fat12cw_pkg::TBL_ADDR_W-1:0] off_hi;
    logic                               cluster_data;
    logic [15:0]                        entry_word;

    // Unpack the input transfer
    assign in_op    = fat12cw_pkg::op_t'(s_tuser);
    assign in_addr  = s_tdata[12:0];
    assign in_byte  = s_tdata[20:13];
    assign in_start = s_tdata[32:21];

    // Hold both input channels off while in reset
    assign s_tready  = aresetn && (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = aresetn;

    // Entry offset cluster*3/2 and data-cluster check
    assign off_lo = {1'b0, cluster_reg} + {2'b00, cluster_reg[fat12cw_pkg::CLUSTER_W-1:1]};
    assign off_hi = off_lo + 13'd1;
    assign cluster_data = (cluster_reg >= fat12cw_pkg::FIRST_DATA) &&
                          (cluster_reg < fat12cw_pkg::END_MARK);
    assign entry_word = {(hi_ok_reg ? tbl_rdata : 8'h00), lo_reg};

    fat12cw_table #(
        .DEPTH (TABLE_BYTES)
    ) u_table (
        .aclk  (aclk),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    fat12cw_sector u_sector (
        .aclk       (aclk),
        .load       (calc_load),
        .cluster    (cluster_reg),
        .data_start (data_start_reg),
        .spc        (spc_reg),
        .result     (calc_result)
    );

    // Sequencer: accept an item, read two table bytes on an advance from a data cluster, multiply, add and hand over
    always_comb begin
        state_next      = state_reg;
        cluster_next    = cluster_reg;
        data_start_next = data_start_reg;
        spc_next        = spc_reg;
        lo_next         = lo_reg;
        lo_ok_next      = lo_ok_reg;
        hi_ok_next      = hi_ok_reg;
        m_valid_next    = m_valid_reg;
        out_next        = out_reg;
        calc_load       = 1'b0;
        tbl_req.we      = 1'b0;
        tbl_req.addr    = off_lo;
        tbl_req.wdata   = in_byte;

        // Configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                fat12cw_pkg::CFG_DATA_START: data_start_next = cfg_data;
                fat12cw_pkg::CFG_SPC:        spc_next = cfg_data[fat12cw_pkg::SPC_W-1:0];
                default: ;
            endcase
        end

        // Drop the result once its transfer completes
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = ST_MUL;
                    case (in_op)
                        fat12cw_pkg::OP_WRITE: begin
                            tbl_req.we   = ({1'b0, in_addr} < TABLE_LIMIT);
                            tbl_req.addr = in_addr;
                        end
                        fat12cw_pkg::OP_START: begin
                            cluster_next = in_start;
                        end
                        fat12cw_pkg::OP_ADVANCE: begin
                            if (cluster_data) begin
                                lo_ok_next = ({1'b0, off_lo} < TABLE_LIMIT);
                                hi_ok_next = ({1'b0, off_hi} < TABLE_LIMIT);
                                state_next = ST_RD_LO;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_LO: begin
                // Hold the low byte, fetch the high one
                lo_next      = lo_ok_reg ? tbl_rdata : 8'h00;
                tbl_req.addr = off_hi;
                state_next   = ST_RD_HI;
            end
            ST_RD_HI: begin
                // Even clusters take the low 12 bits, odd ones the top 12
                if (cluster_reg[0]) begin
                    cluster_next = entry_word[15:4];
                end else begin
                    cluster_next = entry_word[11:0];
                end
                state_next = ST_MUL;
            end
            ST_MUL: begin
                calc_load  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (!m_valid_reg || m_tready) begin
                    out_next     = calc_result;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cluster_reg    <= '0;
            data_start_reg <= '0;
            spc_reg        <= 8'd1;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cluster_reg    <= cluster_next;
            data_start_reg <= data_start_next;
            spc_reg        <= spc_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        lo_reg    <= lo_next;
        lo_ok_reg <= lo_ok_next;
        hi_ok_reg <= hi_ok_next;
        out_reg   <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_reg.current_cluster, out_reg.sector_address};
    assign m_tlast  = out_reg.chain_end;
    assign m_tuser  = out_reg.bad_cluster;

endmodule

FILE: sv/fat12cw_table.sv
`timescale 1ns / 1ps

module fat12cw_table #(
    parameter int unsigned DEPTH = 8192
) (
    input  logic                        aclk,
    input  fat12cw_pkg::tbl_req_t       req,
    output logic [fat12cw_pkg::BYTE_W-1:0] rdata
);

    localparam int unsigned ADDR_W = $clog2(DEPTH);

    logic [fat12cw_pkg::BYTE_W-1:0] mem_array [DEPTH];
    logic [fat12cw_pkg::BYTE_W-1:0] rdata_reg;

    // Single port: optional write and a registered read of the old contents at one address
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_array[req.addr[ADDR_W-1:0]] <= req.wdata;
        end
        rdata_reg <= mem_array[req.addr[ADDR_W-1:0]];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/fat12cw_sector.sv
`timescale 1ns / 1ps

module fat12cw_sector (
    input  logic                                 aclk,
    input  logic                                 load,
    input  logic [fat12cw_pkg::CLUSTER_W-1:0]    cluster,
    input  logic [fat12cw_pkg::START_W-1:0]      data_start,
    input  logic [fat12cw_pkg::SPC_W-1:0]        spc,
    output fat12cw_pkg::result_t                 result
);

    logic [fat12cw_pkg::SECTOR_W-1:0]  product_reg, product_next;
    logic [fat12cw_pkg::START_W-1:0]   start_reg, start_next;
    logic [fat12cw_pkg::CLUSTER_W-1:0] cluster_reg, cluster_next;
    logic                              end_reg, end_next;
    logic                              bad_reg, bad_next;
    logic [fat12cw_pkg::CLUSTER_W-1:0] rel_cluster;
    logic [fat12cw_pkg::SECTOR_W:0]    sum;

    // Stage one: flags and cluster offset times sectors per cluster
    always_comb begin
        rel_cluster  = cluster - fat12cw_pkg::FIRST_DATA;
        product_next = product_reg;
        start_next   = start_reg;
        cluster_next = cluster_reg;
        end_next     = end_reg;
        bad_next     = bad_reg;
        if (load) begin
            product_next = fat12cw_pkg::SECTOR_W'(rel_cluster) *
                           fat12cw_pkg::SECTOR_W'(spc);
            start_next   = data_start;
            cluster_next = cluster;
            end_next     = (cluster >= fat12cw_pkg::END_MARK);
            bad_next     = (cluster < fat12cw_pkg::FIRST_DATA);
        end
    end

    always_ff @(posedge aclk) begin
        product_reg <= product_next;
        start_reg   <= start_next;
        cluster_reg <= cluster_next;
        end_reg     <= end_next;
        bad_reg     <= bad_next;
    end

    // Stage two: add data start, saturate, zero when not a data cluster
    always_comb begin
        sum = {1'b0, product_reg} + (fat12cw_pkg::SECTOR_W + 1)'(start_reg);
        result.current_cluster = cluster_reg;
        result.chain_end       = end_reg;
        result.bad_cluster     = bad_reg;
        if (end_reg || bad_reg) begin
            result.sector_address = '0;
        end else if (sum[fat12cw_pkg::SECTOR_W]) begin
            result.sector_address = fat12cw_pkg::SECTOR_MAX;
        end else begin
            result.sector_address = sum[fat12cw_pkg::SECTOR_W-1:0];
        end
    end

endmodule

FILE: sim/fat12_cluster_chain_walker_unit_test.sv
`timescale 1ns / 1ps

module fat12_cluster_chain_walker_unit_test;

    localparam int unsigned TABLE_BYTES  = 8192;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_ITEMS  = 1850 / PHASES;
    localparam int unsigned LINK_HISTORY = 64;

    // Operation code outside the defined set, and a register index with no register
    localparam logic [1:0] OP_NONE    = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // Register settings per phase: both extremes, zero and oversized cluster sizes
    localparam logic [15:0] PHASE_START [PHASES] =
        '{16'hFFFF, 16'h1234, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
    localparam logic [7:0]  PHASE_SPC [PHASES] = '{8'd128, 8'd0, 8'd255, 8'd1, 8'd1, 8'd1};
    localparam bit          PHASE_RANDOM [PHASES] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};

    typedef struct packed {
        logic [1:0]                          op;
        logic [fat12cw_pkg::TBL_ADDR_W-1:0]  addr;
        logic [fat12cw_pkg::BYTE_W-1:0]      value;
        logic [fat12cw_pkg::CLUSTER_W-1:0]   cluster;
        logic                                typed;
        fat12cw_pkg::result_t                want;
    } step_row_t;

    // Directed steps; typed rows rely on the register values after reset
    localparam int unsigned DIRECTED_ROWS = 22;
    localparam step_row_t DIRECTED_STEPS [DIRECTED_ROWS] = '{
        '{fat12cw_pkg::OP_ADVANCE, 13'h0000, 8'h00, 12'h000, 1'b1,
          '{1'b1, 1'b0, 12'h000, 20'h00000}},
        '{fat12cw_pkg::OP_START,   13'h1FFF, 8'hFF, 12'h000, 1'b1,
          '{1'b1, 1'b0, 12'h000, 20'h00000}},
        '{fat12cw_pkg::OP_START,   13'h0AAA, 8'h55, 12'h001, 1'b1,
          '{1'b1, 1'b0, 12'h001, 20'h00000}},
        '{fat12cw_pkg::OP_START,   13'h1555, 8'hAA, 12'h002, 1'b1,
          '{1'b0, 1'b0, 12'h002, 20'h00000}},
        '{fat12cw_pkg::OP_START,   13'h0000, 8'h00, 12'hFFF, 1'b1,
          '{1'b0, 1'b1, 12'hFFF, 20'h00000}},
        '{fat12cw_pkg::OP_START,   13'h0000, 8'h00, 12'hFF8, 1'b1,
          '{1'b0, 1'b1, 12'hFF8, 20'h00000}},
        '{fat12cw_pkg::OP_ADVANCE, 13'h1FFF, 8'hFF, 12'hFFF, 1'b1,
          '{1'b0, 1'b1, 12'hFF8, 20'h00000}},
        '{fat12cw_pkg::OP_START,   13'h0000, 8'h00, 12'hFF7, 1'b1,
          '{1'b0, 1'b0, 12'hFF7, 20'h00FF5}},
        '{fat12cw_pkg::OP_WRITE,   13'h0003, 8'h03, 12'hFFF, 1'b0, '0},
        '{fat12cw_pkg::OP_WRITE,   13'h0004, 8'hF0, 12'h000, 1'b0, '0},
        '{fat12cw_pkg::OP_WRITE,   13'h0005, 8'hFF, 12'hABC, 1'b0, '0},
        '{fat12cw_pkg::OP_START,   13'h0000, 8'h00, 12'h002, 1'b0, '0},
        '{fat12cw_pkg::OP_ADVANCE, 13'h0000, 8'h00, 12'h000, 1'b0, '0},
        '{fat12cw_pkg::OP_ADVANCE, 13'h0000, 8'h00, 12'h000, 1'b1,
          '{1'b0, 1'b1, 12'hFFF, 20'h00000}},
        '{fat12cw_pkg::OP_ADVANCE, 13'h1FFF, 8'hFF, 12'hFFF, 1'b1,
          '{1'b0, 1'b1, 12'hFFF, 20'h00000}},
        '{fat12cw_pkg::OP_WRITE,   13'h1FFF, 8'hFF, 12'hFFF, 1'b0, '0},
        '{fat12cw_pkg::OP_WRITE,   13'h0000, 8'h00, 12'h000, 1'b0, '0},
        '{OP_NONE,                 13'h1FFF, 8'hFF, 12'hFFF, 1'b0, '0},
        '{fat12cw_pkg::OP_WRITE,   13'h17F2, 8'h20, 12'h000, 1'b0, '0},
        '{fat12cw_pkg::OP_WRITE,   13'h17F3, 8'h00, 12'h000, 1'b0, '0},
        '{fat12cw_pkg::OP_START,   13'h0000, 8'h00, 12'hFF7, 1'b1,
          '{1'b0, 1'b0, 12'hFF7, 20'h00FF5}},
        '{fat12cw_pkg::OP_ADVANCE, 13'h0000, 8'h00, 12'h000, 1'b0, '0}
    };

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    // Shadow of the table and the walker state
    logic [fat12cw_pkg::BYTE_W-1:0]    fat_image [TABLE_BYTES];
    bit                                fat_known [TABLE_BYTES];
    logic [fat12cw_pkg::CLUSTER_W-1:0] cur_cluster      = '0;
    logic [fat12cw_pkg::START_W-1:0]   data_start       = '0;
    logic [fat12cw_pkg::SPC_W-1:0]     sectors_per_clus = 8'd1;

    fat12cw_pkg::result_t              pending_results [$];
    logic [fat12cw_pkg::CLUSTER_W-1:0] linked_clusters [$];

    int          fail_count   = 0;
    int unsigned items_sent   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned hold_request = 0;
    bit          src_gaps     = 1'b1;
    bit          sink_gaps    = 1'b1;

    fat12_cluster_chain_walker_unit #(
        .TABLE_BYTES (TABLE_BYTES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic bit is_data(input logic [fat12cw_pkg::CLUSTER_W-1:0] c);
        return c >= fat12cw_pkg::FIRST_DATA && c < fat12cw_pkg::END_MARK;
    endfunction

    // Byte offset of a 12-bit entry: one and a half bytes per cluster
    function automatic int unsigned entry_offset(input logic [fat12cw_pkg::CLUSTER_W-1:0] c);
        return (c * 3) / 2;
    endfunction

    function automatic logic [fat12cw_pkg::BYTE_W-1:0] table_byte(input int unsigned off);
        return (off < TABLE_BYTES) ? fat_image[off] : '0;
    endfunction

    // Status report for a cluster: first sector, or an end or bad flag
    function automatic fat12cw_pkg::result_t chain_status(
        input logic [fat12cw_pkg::CLUSTER_W-1:0] c);
        fat12cw_pkg::result_t r;
        int unsigned          sector;
        r.current_cluster = c;
        r.chain_end       = c >= fat12cw_pkg::END_MARK;
        r.bad_cluster     = c < fat12cw_pkg::FIRST_DATA;
        r.sector_address  = '0;
        if (!r.chain_end && !r.bad_cluster) begin
            sector = data_start + (c - fat12cw_pkg::FIRST_DATA) * sectors_per_clus;
            r.sector_address = (sector > fat12cw_pkg::SECTOR_MAX) ?
                               fat12cw_pkg::SECTOR_MAX : sector[fat12cw_pkg::SECTOR_W-1:0];
        end
        return r;
    endfunction

    // Advance the shadow state by one accepted item
    function automatic void apply_item(input logic [1:0] op,
                                       input logic [fat12cw_pkg::TBL_ADDR_W-1:0] addr,
                                       input logic [fat12cw_pkg::BYTE_W-1:0] value,
                                       input logic [fat12cw_pkg::CLUSTER_W-1:0] cluster);
        int unsigned off;
        logic [15:0] word;
        case (op)
            fat12cw_pkg::OP_WRITE: begin
                if (addr < TABLE_BYTES) begin
                    fat_image[addr] = value;
                    fat_known[addr] = 1'b1;
                end
            end
            fat12cw_pkg::OP_START: begin
                cur_cluster = cluster;
            end
            fat12cw_pkg::OP_ADVANCE: begin
                if (is_data(cur_cluster)) begin
                    off  = entry_offset(cur_cluster);
                    word = {table_byte(off + 1), table_byte(off)};
                    cur_cluster = cur_cluster[0] ? word[15:4] : word[11:0];
                end
            end
            default: ;
        endcase
    endfunction

    // Offer one item, wait for its transfer, then record what it should answer
    task automatic offer_item(input logic [1:0] op,
                              input logic [fat12cw_pkg::TBL_ADDR_W-1:0] addr,
                              input logic [fat12cw_pkg::BYTE_W-1:0] value,
                              input logic [fat12cw_pkg::CLUSTER_W-1:0] cluster,
                              input logic typed, input fat12cw_pkg::result_t want);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, cluster, value, addr};
        do @(posedge aclk); while (!s_tready);
        apply_item(op, addr, value, cluster);
        pending_results.push_back(typed ? want : chain_status(cur_cluster));
        items_sent++;
    endtask

    task automatic write_register(input logic [1:0] index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index == fat12cw_pkg::CFG_DATA_START)
            data_start = value;
        else if (index == fat12cw_pkg::CFG_SPC)
            sectors_per_clus = value[fat12cw_pkg::SPC_W-1:0];
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Next link of a chain: mostly data clusters, some ends, bad ones and revisits
    function automatic logic [fat12cw_pkg::CLUSTER_W-1:0] pick_cluster();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return 12'($urandom_range(fat12cw_pkg::END_MARK, 12'hFFF));
        if (roll < 14)
            return 12'($urandom_range(0, 1));
        if (roll < 34 && linked_clusters.size() > 0)
            return linked_clusters[$urandom_range(0, linked_clusters.size() - 1)];
        if (roll < 60)
            return 12'($urandom_range(fat12cw_pkg::FIRST_DATA, 63));
        return 12'($urandom_range(fat12cw_pkg::FIRST_DATA, fat12cw_pkg::END_MARK - 1));
    endfunction

    // Write the entry of cluster c as two bytes, keeping the neighbour's nibble
    task automatic link_entry(input logic [fat12cw_pkg::CLUSTER_W-1:0] c,
                              input logic [fat12cw_pkg::CLUSTER_W-1:0] nxt);
        int unsigned off;
        logic [7:0]  lo;
        logic [7:0]  hi;
        off = entry_offset(c);
        lo  = fat_known[off] ? fat_image[off] : 8'($urandom);
        hi  = fat_known[off + 1] ? fat_image[off + 1] : 8'($urandom);
        if (c[0]) begin
            lo[7:4] = nxt[3:0];
            hi      = nxt[11:4];
        end else begin
            lo      = nxt[7:0];
            hi[3:0] = nxt[11:8];
        end
        if ($urandom_range(0, 1) == 1) begin
            offer_item(fat12cw_pkg::OP_WRITE, 13'(off), lo, 12'($urandom), 1'b0, '0);
            offer_item(fat12cw_pkg::OP_WRITE, 13'(off + 1), hi, 12'($urandom), 1'b0, '0);
        end else begin
            offer_item(fat12cw_pkg::OP_WRITE, 13'(off + 1), hi, 12'($urandom), 1'b0, '0);
            offer_item(fat12cw_pkg::OP_WRITE, 13'(off), lo, 12'($urandom), 1'b0, '0);
        end
        linked_clusters.push_back(c);
        if (linked_clusters.size() > LINK_HISTORY)
            void'(linked_clusters.pop_front());
    endtask

    // One step along a chain; an entry is always written before it is read
    task automatic walk_step();
        logic [fat12cw_pkg::CLUSTER_W-1:0] c;
        int unsigned                       off;
        c = cur_cluster;
        if (is_data(c)) begin
            off = entry_offset(c);
            if (!(fat_known[off] && fat_known[off + 1]) || $urandom_range(0, 3) == 0)
                link_entry(c, pick_cluster());
            offer_item(fat12cw_pkg::OP_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom),
                       1'b0, '0);
        end else if ($urandom_range(0, 3) == 0) begin
            offer_item(fat12cw_pkg::OP_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom),
                       1'b0, '0);
        end else begin
            offer_item(fat12cw_pkg::OP_START, 13'($urandom), 8'($urandom), pick_cluster(),
                       1'b0, '0);
        end
    endtask

    // Result sink: random stalls, and one long hold-off on request
    initial begin : result_sink
        int unsigned n;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (n - 1) @(posedge aclk);
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Compare each result transfer with the oldest pending expectation
    always @(posedge aclk) begin
        fat12cw_pkg::result_t got;
        fat12cw_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tlast, m_tdata};
            if (pending_results.size() == 0) begin
                $error("result with nothing pending: sector_address %0h current_cluster %0h",
                       got.sector_address, got.current_cluster);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.sector_address !== want.sector_address) begin
                    $error("sector_address: expected %0h, got %0h",
                           want.sector_address, got.sector_address);
                    fail_count++;
                end
                if (got.current_cluster !== want.current_cluster) begin
                    $error("current_cluster: expected %0h, got %0h",
                           want.current_cluster, got.current_cluster);
                    fail_count++;
                end
                if (got.chain_end !== want.chain_end) begin
                    $error("chain_end: expected %0b, got %0b", want.chain_end, got.chain_end);
                    fail_count++;
                end
                if (got.bad_cluster !== want.bad_cluster) begin
                    $error("bad_cluster: expected %0b, got %0b",
                           want.bad_cluster, got.bad_cluster);
                    fail_count++;
                end
            end
        end
    end

    // Stop the run when no transfer of any kind happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int unsigned                     ph;
        int unsigned                     roll;
        int unsigned                     target;
        logic [fat12cw_pkg::START_W-1:0] start_sector;
        logic [fat12cw_pkg::SPC_W-1:0]   spc_setting;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed steps under the reset register values
        for (int i = 0; i < DIRECTED_ROWS; i++)
            offer_item(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].addr, DIRECTED_STEPS[i].value,
                       DIRECTED_STEPS[i].cluster, DIRECTED_STEPS[i].typed,
                       DIRECTED_STEPS[i].want);

        for (ph = 0; ph < PHASES; ph++) begin
            // Reconfigure only once the walker is idle
            s_tvalid <= 1'b0;
            wait_for_results();
            start_sector = PHASE_START[ph];
            spc_setting  = PHASE_SPC[ph];
            if (PHASE_RANDOM[ph]) begin
                start_sector = 16'($urandom);
                spc_setting  = 8'($urandom_range(1, 128));
            end
            if ($urandom_range(0, 1) == 1) begin
                write_register(fat12cw_pkg::CFG_DATA_START, start_sector);
                write_register(fat12cw_pkg::CFG_SPC, {8'($urandom), spc_setting});
            end else begin
                write_register(fat12cw_pkg::CFG_SPC, {8'($urandom), spc_setting});
                write_register(fat12cw_pkg::CFG_DATA_START, start_sector);
            end
            if (ph == 1)
                write_register(CFG_UNUSED, 16'($urandom));
            cfg_valid <= 1'b0;

            // Long hold on the result side while items keep coming
            if (ph == 2)
                hold_request = HOLD_CYCLES;
            // Final phase runs without idling on either side
            if (ph == PHASES - 1) begin
                src_gaps  = 1'b0;
                sink_gaps = 1'b0;
            end

            target = items_sent + PHASE_ITEMS;
            while (items_sent < target) begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    offer_item(fat12cw_pkg::OP_START, 13'($urandom), 8'($urandom),
                               12'($urandom), 1'b0, '0);
                else if (roll < 14)
                    offer_item(fat12cw_pkg::OP_WRITE, 13'($urandom), 8'($urandom),
                               12'($urandom), 1'b0, '0);
                else if (roll < 17)
                    offer_item(OP_NONE, 13'($urandom), 8'($urandom), 12'($urandom),
                               1'b0, '0);
                else
                    walk_step();
            end
        end

        // Drain, then allow the pipeline to settle
        s_tvalid <= 1'b0;
        wait_for_results();
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
